// ----- rtl/nfb_pkg.sv -----
`default_nettype none

package nfb_pkg;

  localparam int DATA_W  = 16;
  localparam int ACC_W   = 38;
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 20;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

  typedef enum logic [1:0] {
    REQ_ACT    = 2'd0,
    REQ_TARGET = 2'd1,
    REQ_ERROR  = 2'd2,
    REQ_WLOAD  = 2'd3
  } req_type_e;

  localparam logic [1:0] CFG_LEARN_RATE = 2'd0;
  localparam logic [1:0] CFG_MOMENTUM   = 2'd1;
  localparam logic [1:0] CFG_ACT_MODE   = 2'd2;

  localparam logic RES_OUTPUT   = 1'b0;
  localparam logic RES_GRADIENT = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_F_MUL,
    ST_F_ACC,
    ST_F_RND,
    ST_T_MUL,
    ST_T_LUT,
    ST_T_OUT,
    ST_G_YY,
    ST_G_D,
    ST_G_UD,
    ST_G_G,
    ST_U_X,
    ST_U_XG,
    ST_U_P,
    ST_U_Q
  } state_e;

  typedef struct packed {
    logic                       en;
    logic signed [MUL_A_W-1:0]  a;
    logic signed [MUL_B_W-1:0]  b;
  } mul_req_t;

  function automatic logic signed [15:0] sat16(logic signed [53:0] v);
    if (v > 54'sd32767) return 16'sh7fff;
    if (v < -54'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // shift-subtract divide, used only on constants while building the table
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], num[k]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] mul_q32(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    p = p + (128'd1 << 31);
    return p[95:32];
  endfunction

  // tanh at bin center, q4.12, via exp(-2x) from repeated squares
  function automatic logic signed [15:0] tanh_entry(int unsigned i, int unsigned size);
    logic [63:0] e [16];
    logic [63:0] x;
    logic [63:0] two_x;
    logic [63:0] t;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    e[0] = ONE_Q32 - (64'd1 << 20) + (64'd1 << 7);
    for (int k = 1; k < 16; k++) e[k] = mul_q32(e[k-1], e[k-1]);
    x = udiv64(64'(2 * i + 1) * 64'd16384, 64'(size));
    two_x = (x << 1) & 64'h0000_0000_0000_ffff;
    t = ONE_Q32;
    for (int k = 0; k < 16; k++) begin
      if (two_x[k]) t = mul_q32(t, e[k]);
    end
    num = (ONE_Q32 - t) * 64'd4096;
    den = ONE_Q32 + t;
    q = udiv64(num + (den >> 1), den);
    return q[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/neuron_forward_backprop_momentum.sv -----
`default_nettype none

// single neuron: weight store, momentum deltas and latched activations
// input channel: start/busy command port, one beat taken when start is high and busy low
// result channel: result_valid_o strobes one cycle with result_value_o/result_kind_o,
//   the receiver takes every beat, nothing is held back
// config: cfg_we_i writes learn rate, momentum or activation mode; write while idle
// steps: all work goes through one registered multiplier under the sequencer:
//   weight load       written from idle, busy stays low
//   activation beat   weight read, multiply, accumulate
//   last beat         then rounding, and for tanh also scale, table read, sign
//   training beat     the gradient first, then for each used weight
//     (activation times eta, times gradient, momentum product, write back)
// a result leaves in the cycle busy drops, so the next beat can follow at once
// reset: busy stays high while the delta store is swept to zero, config
//   registers go to their defaults
module neuron_forward_backprop_momentum #(
  parameter int MAX_INPUTS      = 64,
  parameter int TANH_TABLE_SIZE = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [5:0]  index_i,
  input  wire logic signed [15:0] value_i,
  input  wire logic        last_i,
  output logic             result_valid_o,
  output logic signed [15:0] result_value_o,
  output logic             result_kind_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import nfb_pkg::*;

  localparam int AW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int UW  = $clog2(MAX_INPUTS + 1);
  localparam int IXW = ((AW > 6) ? AW : 6) + 1;
  localparam int LW  = $clog2(TANH_TABLE_SIZE);

  // constant tanh table
  logic signed [15:0] tanh_lut [TANH_TABLE_SIZE];
  for (genvar gi = 0; gi < TANH_TABLE_SIZE; gi++) begin : g_lut
    localparam logic signed [15:0] TanhVal = tanh_entry(gi, TANH_TABLE_SIZE);
    assign tanh_lut[gi] = TanhVal;
  end

  // registers
  state_e                   state_q, state_d;
  logic [AW-1:0]            i_q, i_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [UW-1:0]            used_q, used_d;
  logic                     pass_open_q, pass_open_d;
  logic signed [15:0]       y_q, y_d;
  logic signed [15:0]       value_q, value_d;
  logic                     last_q, last_d;
  logic signed [15:0]       sum_q, sum_d;
  logic signed [16:0]       u_q, u_d;
  logic signed [18:0]       d_q, d_d;
  logic signed [15:0]       g_q, g_d;
  logic signed [20:0]       pt_q, pt_d;
  logic signed [15:0]       lut_q;
  logic                     res_valid_q, res_valid_d;
  logic signed [15:0]       res_value_q, res_value_d;
  logic                     res_kind_q, res_kind_d;
  logic [15:0]              lr_q, mom_q;
  logic                     mode_q;

  // stores
  logic signed [15:0] w_mem   [MAX_INPUTS];
  logic signed [15:0] dw_mem  [MAX_INPUTS];
  logic signed [15:0] act_mem [MAX_INPUTS];
  logic signed [15:0] w_rd_q, dw_rd_q, act_rd_q;
  logic               w_we, dw_we, a_we, rd_en, lut_en;
  logic [AW-1:0]      w_wa, dw_wa, rd_addr;
  logic signed [15:0] w_wd, dw_wd;

  mul_req_t                  mul_req;
  logic signed [MUL_P_W-1:0] p;

  nfb_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (p)
  );

  // input index decode
  logic [IXW-1:0] idx_ext;
  logic           in_range;
  logic [AW-1:0]  addr_in;
  logic [UW-1:0]  idx_plus1;
  logic [UW-1:0]  used_base;

  assign idx_ext   = IXW'(index_i);
  assign in_range  = idx_ext < IXW'(MAX_INPUTS);
  assign addr_in   = idx_ext[AW-1:0];
  assign idx_plus1 = UW'(idx_ext + 1'b1);
  assign used_base = pass_open_q ? used_q : '0;

  // datapath around the product register
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W-1:0] acc_sat;
  logic signed [ACC_W:0]   acc_r;
  logic signed [15:0]      s_fwd;
  logic signed [16:0]      abs_sum;
  logic [LW:0]             tix_raw;
  logic [LW-1:0]           tix;
  logic signed [15:0]      tanh_y;
  logic signed [MUL_P_W-1:0] p_r12, p_r16, p_r28;
  logic signed [53:0]      d_calc;
  logic signed [15:0]      g_calc;
  logic signed [16:0]      q_term;
  logic signed [15:0]      nd;
  logic signed [15:0]      w_new;
  logic                    last_iter;

  assign acc_sum = {acc_q[ACC_W-1], acc_q} + p[ACC_W:0];
  assign acc_sat = (acc_sum[ACC_W] != acc_sum[ACC_W-1])
                   ? (acc_sum[ACC_W] ? 38'h20_0000_0000 : 38'h1f_ffff_ffff)
                   : acc_sum[ACC_W-1:0];
  assign acc_r   = {acc_q[ACC_W-1], acc_q} + 39'sd2048;
  assign s_fwd   = sat16(54'(acc_r >>> 12));

  assign abs_sum = sum_q[15] ? -{sum_q[15], sum_q} : {sum_q[15], sum_q};
  assign tix_raw = p[15 +: LW+1];
  assign tix     = (tix_raw >= (LW+1)'(TANH_TABLE_SIZE)) ? LW'(TANH_TABLE_SIZE - 1)
                                                         : tix_raw[LW-1:0];
  assign tanh_y  = sum_q[15] ? -lut_q : lut_q;

  assign p_r12  = (p + 53'sd2048) >>> 12;
  assign p_r16  = (p + 53'sd32768) >>> 16;
  assign p_r28  = (p + 53'sh800_0000) >>> 28;
  assign d_calc = 54'sd4096 - 54'(p_r12);
  assign g_calc = sat16(54'(p_r12));
  assign q_term = p_r16[16:0];
  assign nd     = sat16(54'(pt_q) + 54'(q_term));
  assign w_new  = sat16(54'(w_rd_q) + 54'(nd));

  assign last_iter = (UW'(i_q) + 1'b1) == used_q;

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    acc_d       = acc_q;
    used_d      = used_q;
    pass_open_d = pass_open_q;
    y_d         = y_q;
    value_d     = value_q;
    last_d      = last_q;
    sum_d       = sum_q;
    u_d         = u_q;
    d_d         = d_q;
    g_d         = g_q;
    pt_d        = pt_q;
    res_valid_d = 1'b0;
    res_value_d = res_value_q;
    res_kind_d  = res_kind_q;
    mul_req     = '0;
    rd_en       = 1'b0;
    rd_addr     = addr_in;
    lut_en      = 1'b0;
    w_we        = 1'b0;
    w_wa        = addr_in;
    w_wd        = value_i;
    dw_we       = 1'b0;
    dw_wa       = addr_in;
    dw_wd       = '0;
    a_we        = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        dw_we = 1'b1;
        dw_wa = i_q;
        if (i_q == AW'(MAX_INPUTS - 1)) begin
          i_d     = '0;
          state_d = ST_IDLE;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          value_d = value_i;
          last_d  = last_i;
          case (req_type_i)
            REQ_ACT: begin
              // first beat of a pass clears the sum and the used count
              pass_open_d = 1'b1;
              used_d      = used_base;
              if (!pass_open_q) acc_d = '0;
              if (in_range) begin
                a_we  = 1'b1;
                rd_en = 1'b1;
                if (idx_plus1 > used_base) used_d = idx_plus1;
                state_d = ST_F_MUL;
              end else if (last_i) begin
                state_d = ST_F_RND;
              end
            end
            REQ_WLOAD: begin
              if (in_range) begin
                w_we  = 1'b1;
                dw_we = 1'b1;
              end
            end
            REQ_TARGET: begin
              u_d     = 17'(value_i) - 17'(y_q);
              state_d = ST_G_YY;
            end
            default: begin
              u_d     = 17'(value_i);
              state_d = ST_G_YY;
            end
          endcase
        end
      end
      ST_F_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'(value_q);
        mul_req.b  = MUL_B_W'(w_rd_q);
        state_d    = ST_F_ACC;
      end
      ST_F_ACC: begin
        acc_d   = acc_sat;
        state_d = last_q ? ST_F_RND : ST_IDLE;
      end
      ST_F_RND: begin
        if (mode_q) begin
          y_d         = s_fwd;
          pass_open_d = 1'b0;
          res_valid_d = 1'b1;
          res_value_d = s_fwd;
          res_kind_d  = RES_OUTPUT;
          state_d     = ST_IDLE;
        end else begin
          sum_d   = s_fwd;
          state_d = ST_T_MUL;
        end
      end
      ST_T_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'(abs_sum);
        mul_req.b  = MUL_B_W'(TANH_TABLE_SIZE);
        state_d    = ST_T_LUT;
      end
      ST_T_LUT: begin
        lut_en  = 1'b1;
        state_d = ST_T_OUT;
      end
      ST_T_OUT: begin
        y_d         = tanh_y;
        pass_open_d = 1'b0;
        res_valid_d = 1'b1;
        res_value_d = tanh_y;
        res_kind_d  = RES_OUTPUT;
        state_d     = ST_IDLE;
      end
      ST_G_YY: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'(y_q);
        mul_req.b  = MUL_B_W'(y_q);
        state_d    = ST_G_D;
      end
      ST_G_D: begin
        d_d     = d_calc[18:0];
        state_d = ST_G_UD;
      end
      ST_G_UD: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'(u_q);
        mul_req.b  = MUL_B_W'(d_q);
        state_d    = ST_G_G;
      end
      ST_G_G: begin
        g_d = g_calc;
        if (used_q == '0) begin
          res_valid_d = 1'b1;
          res_value_d = g_calc;
          res_kind_d  = RES_GRADIENT;
          state_d     = ST_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = '0;
          i_d     = '0;
          state_d = ST_U_X;
        end
      end
      ST_U_X: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'(act_rd_q);
        mul_req.b  = MUL_B_W'({1'b0, lr_q});
        state_d    = ST_U_XG;
      end
      ST_U_XG: begin
        mul_req.en = 1'b1;
        mul_req.a  = p[MUL_A_W-1:0];
        mul_req.b  = MUL_B_W'(g_q);
        state_d    = ST_U_P;
      end
      ST_U_P: begin
        pt_d       = p_r28[20:0];
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'(dw_rd_q);
        mul_req.b  = MUL_B_W'({1'b0, mom_q});
        state_d    = ST_U_Q;
      end
      ST_U_Q: begin
        w_we  = 1'b1;
        w_wa  = i_q;
        w_wd  = w_new;
        dw_we = 1'b1;
        dw_wa = i_q;
        dw_wd = nd;
        if (last_iter) begin
          res_valid_d = 1'b1;
          res_value_d = g_q;
          res_kind_d  = RES_GRADIENT;
          state_d     = ST_IDLE;
        end else begin
          i_d     = i_q + 1'b1;
          rd_en   = 1'b1;
          rd_addr = i_q + 1'b1;
          state_d = ST_U_X;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      i_q         <= '0;
      acc_q       <= '0;
      used_q      <= '0;
      pass_open_q <= 1'b0;
      y_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      acc_q       <= acc_d;
      used_q      <= used_d;
      pass_open_q <= pass_open_d;
      y_q         <= y_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q     <= value_d;
    last_q      <= last_d;
    sum_q       <= sum_d;
    u_q         <= u_d;
    d_q         <= d_d;
    g_q         <= g_d;
    pt_q        <= pt_d;
    res_value_q <= res_value_d;
    res_kind_q  <= res_kind_d;
    if (lut_en) lut_q <= tanh_lut[tix];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q   <= 16'd6554;
      mom_q  <= 16'd32768;
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LEARN_RATE: lr_q   <= cfg_data_i;
        CFG_MOMENTUM:   mom_q  <= cfg_data_i;
        CFG_ACT_MODE:   mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_we) w_mem[w_wa] <= w_wd;
    if (rd_en) w_rd_q <= w_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (dw_we) dw_mem[dw_wa] <= dw_wd;
    if (rd_en) dw_rd_q <= dw_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (a_we) act_mem[addr_in] <= value_i;
    if (rd_en) act_rd_q <= act_mem[rd_addr];
  end

  assign busy           = state_q != ST_IDLE;
  assign result_valid_o = res_valid_q;
  assign result_value_o = res_value_q;
  assign result_kind_o  = res_kind_q;

endmodule

`default_nettype wire

// ----- rtl/nfb_mul.sv -----
`default_nettype none

module nfb_mul (
  input  wire logic                                 clk_i,
  input  wire nfb_pkg::mul_req_t                    req_i,
  output logic signed [nfb_pkg::MUL_P_W-1:0]        prod_o
);
  import nfb_pkg::*;

  logic signed [MUL_P_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= req_i.a * req_i.b;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ----- rtl/nfb_checker.sv -----
`default_nettype none

module nfb_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] req_type_i,
  input wire logic       last_i,
  input wire logic       result_valid_o
);
  import nfb_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // results leave exactly as the sequencer returns to idle
  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result beat while busy");

  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result beat repeated");

  a_wload_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == REQ_WLOAD) |=> (!busy && !result_valid_o))
    else $error("weight load stalled or produced a result");

  a_train_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i == REQ_TARGET || req_type_i == REQ_ERROR)) |=> busy)
    else $error("training beat did not start the sequencer");

  a_act_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == REQ_ACT) |=> !result_valid_o)
    else $error("activation beat gave a result too early");

endmodule

bind neuron_forward_backprop_momentum nfb_checker u_nfb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .req_type_i     (req_type_i),
  .last_i         (last_i),
  .result_valid_o (result_valid_o)
);

`default_nettype wire
